// File: sv/msd_pkg.sv
package msd_pkg;

	// Debouncer state per switch, encoded as reported on the result port.
	typedef enum logic [1:0] {
		ST_RELEASED    = 2'd0,
		ST_PREPRESSED  = 2'd1,
		ST_PRESSED     = 2'd2,
		ST_PRERELEASED = 2'd3
	} db_state_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_PREPRESS_THR   = 3'd0,
		REG_PRESS_THR      = 3'd1,
		REG_PRERELEASE_THR = 3'd2,
		REG_RELEASE_THR    = 3'd3,
		REG_ACTIVE_LOW     = 3'd4
	} cfg_reg_t;

	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned CNT_W       = 8;
	localparam int unsigned PIN_W       = 8;
	localparam int unsigned STATES_W    = 16;

	localparam logic [CNT_W-1:0] CNT_MAX            = '1;
	localparam logic [7:0]       PREPRESS_THR_RST   = 8'd20;
	localparam logic [7:0]       PRESS_THR_RST      = 8'd25;
	localparam logic [7:0]       PRERELEASE_THR_RST = 8'd20;
	localparam logic [7:0]       RELEASE_THR_RST    = 8'd25;
	localparam logic [7:0]       ACTIVE_LOW_RST     = 8'hFF;

endpackage

// File: sv/multi_switch_debouncer.sv
// Debouncer for up to NUM_SWITCHES switches sampled together.
// Input channel: in_valid / in_stall with pin_levels, one raw level per switch;
// each transfer is one sample tick. Output channel: out_valid / out_stall with
// switch_states (two bits per switch) and pressed_mask, one result per tick.
// Only the first eight switches have pins; any others see an inactive level.
// A tick is captured in the input register, then all switches update in
// parallel (one compare and increment each) into the result register. One
// tick is taken every cycle as long as the output side keeps taking results;
// the rate is set by the single update stage.
// When out_stall is high the result is held, the input register keeps its
// tick and in_stall rises once both registers are full, so nothing is lost.
// The user must write configuration via cfg_we / cfg_index / cfg_data only while
// the block is idle; it is not enforced. Indexes past the last register are ignored.
// Reset loads the default thresholds (20, 25, 20, 25) and all-pull-up
// polarity, puts every switch in released with a zero counter and empties
// both registers.
module multi_switch_debouncer
	import msd_pkg::*;
#(
	parameter int unsigned NUM_SWITCHES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIN_W-1:0]      pin_levels,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATES_W-1:0]   switch_states,
	output logic [PIN_W-1:0]      pressed_mask
);

	localparam int unsigned NUM_VIS = (NUM_SWITCHES < PIN_W) ? NUM_SWITCHES : PIN_W;

	logic [7:0] prepress_thr_q;
	logic [7:0] press_thr_q;
	logic [7:0] prerelease_thr_q;
	logic [7:0] release_thr_q;
	logic [7:0] active_low_q;

	logic             valid_s1;
	logic [PIN_W-1:0] pin_levels_s1;
	logic             advance;

	db_state_t        st_q   [NUM_SWITCHES];
	logic [CNT_W-1:0] cnt_q  [NUM_SWITCHES];
	db_state_t        st_nxt [NUM_SWITCHES];
	logic [CNT_W-1:0] cnt_nxt[NUM_SWITCHES];
	logic [NUM_SWITCHES-1:0] act;

	logic                out_valid_q;
	logic [STATES_W-1:0] states_q;
	logic [PIN_W-1:0]    pmask_q;
	logic [STATES_W-1:0] states_nxt;
	logic [PIN_W-1:0]    pmask_nxt;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prepress_thr_q   <= PREPRESS_THR_RST;
			press_thr_q      <= PRESS_THR_RST;
			prerelease_thr_q <= PRERELEASE_THR_RST;
			release_thr_q    <= RELEASE_THR_RST;
			active_low_q     <= ACTIVE_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PREPRESS_THR:   prepress_thr_q   <= cfg_data;
				REG_PRESS_THR:      press_thr_q      <= cfg_data;
				REG_PRERELEASE_THR: prerelease_thr_q <= cfg_data;
				REG_RELEASE_THR:    release_thr_q    <= cfg_data;
				REG_ACTIVE_LOW:     active_low_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// The update stage moves forward when the result register is free or drained.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_levels_s1 <= pin_levels;
		end
	end

	// Per-switch debouncers, all updated in parallel.
	for (genvar g = 0; g < NUM_SWITCHES; g++) begin : g_sw
		logic             counting;
		logic [CNT_W-1:0] cnt_inc;

		// A pull-up switch is active on a low level; switches without a pin stay inactive.
		if (g < PIN_W) begin : g_pin
			assign act[g] = pin_levels_s1[g] ^ active_low_q[g];
		end else begin : g_nopin
			assign act[g] = 1'b0;
		end

		always_comb begin
			counting   = (st_q[g] == ST_RELEASED || st_q[g] == ST_PREPRESSED) ? act[g] : !act[g];
			cnt_inc    = (cnt_q[g] == CNT_MAX) ? CNT_MAX : cnt_q[g] + 1'b1;
			st_nxt[g]  = st_q[g];
			cnt_nxt[g] = cnt_inc;
			if (!counting) begin
				// A level of the other kind clears the count and undoes a pre state.
				cnt_nxt[g] = '0;
				if (st_q[g] == ST_PREPRESSED) begin
					st_nxt[g] = ST_RELEASED;
				end else if (st_q[g] == ST_PRERELEASED) begin
					st_nxt[g] = ST_PRESSED;
				end
			end else begin
				case (st_q[g])
					ST_RELEASED: begin
						if (cnt_inc == prepress_thr_q) st_nxt[g] = ST_PREPRESSED;
					end
					ST_PREPRESSED: begin
						if (cnt_inc == press_thr_q) begin
							st_nxt[g]  = ST_PRESSED;
							cnt_nxt[g] = '0;
						end
					end
					ST_PRESSED: begin
						if (cnt_inc == prerelease_thr_q) st_nxt[g] = ST_PRERELEASED;
					end
					ST_PRERELEASED: begin
						if (cnt_inc == release_thr_q) begin
							st_nxt[g]  = ST_RELEASED;
							cnt_nxt[g] = '0;
						end
					end
					default: ;
				endcase
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_q[g]  <= ST_RELEASED;
				cnt_q[g] <= '0;
			end else if (advance) begin
				st_q[g]  <= st_nxt[g];
				cnt_q[g] <= cnt_nxt[g];
			end
		end
	end

	// Pack the visible switches into the result; pressed and pre-released share bit one.
	always_comb begin
		states_nxt = '0;
		pmask_nxt  = '0;
		for (int i = 0; i < NUM_VIS; i++) begin
			states_nxt[2*i +: 2] = st_nxt[i];
			pmask_nxt[i]         = st_nxt[i][1];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			states_q <= states_nxt;
			pmask_q  <= pmask_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign switch_states = states_q;
	assign pressed_mask  = pmask_q;

	// The input side only stalls while a tick waits behind a held result.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("in_stall raised without a blocked tick");

	// For switch zero, the mask bit reported with a result agrees with its reported state.
	a_mask_matches_states: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pressed_mask[0] == switch_states[1]))
		else $error("pressed_mask disagrees with switch_states");

	for (genvar g = 0; g < NUM_SWITCHES; g++) begin : g_chk
		// Released never jumps straight into the pressed half.
		a_no_skip_press: assert property (@(posedge clk) disable iff (!arst_n)
			(st_q[g] == ST_RELEASED) |=> (st_q[g] == ST_RELEASED || st_q[g] == ST_PREPRESSED))
			else $error("switch skipped pre-pressed");

		// Entering pressed from pre-pressed always starts with a cleared counter.
		a_press_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
			(st_q[g] == ST_PREPRESSED && advance && st_nxt[g] == ST_PRESSED)
			|=> (cnt_q[g] == '0))
			else $error("counter not cleared on press");
	end

endmodule
